### rtl/xasc_pkg.sv
// shared types, flag positions and operation codes for the add/sub/compare alu
package xasc_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned BYTE_W = 8;

    localparam int unsigned FLAG_CF_BIT = 0;
    localparam int unsigned FLAG_PF_BIT = 2;
    localparam int unsigned FLAG_AF_BIT = 4;
    localparam int unsigned FLAG_ZF_BIT = 6;
    localparam int unsigned FLAG_SF_BIT = 7;
    localparam int unsigned FLAG_OF_BIT = 11;

    localparam logic [DATA_W-1:0] ARITH_FLAGS_MASK = 16'h08D5;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_CMP = 2'd2,
        ACT_NOP = 2'd3
    } t_action;

    // first stage: masked operands, raw result, carry and aux carry
    typedef struct packed {
        t_action           action;
        logic              word_size;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] flags;
        logic              cf;
        logic              af;
    } t_arith;

    // second stage: all six status flags resolved
    typedef struct packed {
        t_action           action;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] flags;
        logic              cf;
        logic              pf;
        logic              af;
        logic              zf;
        logic              sf;
        logic              of;
    } t_stat;

endpackage

### rtl/xasc_if.sv
// valid/ready channel interfaces for requests and responses
interface xasc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic        word_size;
    logic [15:0] first_operand;
    logic [15:0] second_operand;
    logic [15:0] flags_in;

    modport source (
        output valid, action, word_size, first_operand, second_operand, flags_in,
        input  ready
    );
    modport sink (
        input  valid, action, word_size, first_operand, second_operand, flags_in,
        output ready
    );
endinterface

interface xasc_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] alu_result;
    logic [15:0] flags_out;

    modport source (
        output valid, alu_result, flags_out,
        input  ready
    );
    modport sink (
        input  valid, alu_result, flags_out,
        output ready
    );
endinterface

### rtl/x86_add_sub_cmp_flags_alu.sv
// top level: 8086-style add/subtract/compare alu with flag update
//
// requests come in on i_req (action, word_size, two operands, flags word)
// and one response per request leaves on o_rsp (alu_result, flags_out),
// both valid/ready channels; an item moves when valid and ready are high.
// action codes: add, subtract, compare (flags of subtract, first operand
// returned) and an unused code that passes the masked first operand and
// the flags word through unchanged. byte mode works on the low 8 bits and
// zero-extends the result.
// from request accept to response valid an item passes add/sub with
// carries, then overflow/parity/zero/sign, then result select and flags
// merge into the output register. throughput is one item per cycle
// unless o_rsp stalls; each stage holds its item while the next one is
// full and stalled, so a stall on o_rsp backs up through the stages; up
// to three items are in flight, and nothing is dropped or repeated.
// reset (synchronous, active low) clears all stage valid bits; the block
// accepts requests as soon as reset is released.
module x86_add_sub_cmp_flags_alu (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xasc_req_if.sink   i_req,
    xasc_rsp_if.source o_rsp
);
    import xasc_pkg::*;

    logic   s1_valid;
    logic   s1_ready;
    t_arith s1_data;
    logic   s2_valid;
    logic   s2_ready;
    t_stat  s2_data;

    xasc_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    xasc_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    xasc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_rsp   (o_rsp)
    );

    // an open output lets every stage move, so the input must be open too
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.ready |-> i_req.ready)
        else $error("input blocked while output accepts");

    // a stalled middle stage keeps its item
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_valid && !s2_ready) |=> (s2_valid && $stable(s2_data)))
        else $error("stage 2 item lost during stall");

    // byte mode never leaves bits in the upper result byte
    a_byte_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && !s1_data.word_size) |-> (s1_data.r[15:8] == 8'h00 &&
                                              s1_data.a[15:8] == 8'h00))
        else $error("byte mode result not masked");

endmodule

### rtl/xasc_arith.sv
// stage 1: operand masking, shared add/subtract, carry and auxiliary carry
module xasc_arith (
    input  logic             i_clk,
    input  logic             i_rst_n,
    xasc_req_if.sink         i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output xasc_pkg::t_arith o_data
);
    import xasc_pkg::*;

    logic              r_valid;
    logic              n_valid;
    t_arith            r_data;
    t_arith            n_data;
    logic              advance;
    logic              is_sub;
    logic [DATA_W-1:0] a_m;
    logic [DATA_W-1:0] b_m;
    logic [DATA_W-1:0] b_op;
    logic [DATA_W:0]   sum;
    logic [4:0]        nib;

    assign advance     = !r_valid || i_ready;
    assign i_req.ready = advance;
    assign n_valid     = i_req.valid;

    always_comb begin
        a_m = i_req.word_size ? i_req.first_operand
                              : {{(DATA_W-BYTE_W){1'b0}}, i_req.first_operand[BYTE_W-1:0]};
        b_m = i_req.word_size ? i_req.second_operand
                              : {{(DATA_W-BYTE_W){1'b0}}, i_req.second_operand[BYTE_W-1:0]};
        is_sub = (t_action'(i_req.action) != ACT_ADD);
        b_op   = is_sub ? ~b_m : b_m;
        // subtract as a + ~b + 1; carry out high means no borrow
        sum = {1'b0, a_m} + {1'b0, b_op} + {{DATA_W{1'b0}}, is_sub};
        nib = {1'b0, a_m[3:0]} + {1'b0, b_op[3:0]} + {4'd0, is_sub};

        n_data.action    = t_action'(i_req.action);
        n_data.word_size = i_req.word_size;
        n_data.a         = a_m;
        n_data.b         = b_m;
        n_data.flags     = i_req.flags_in;
        n_data.r         = i_req.word_size ? sum[DATA_W-1:0]
                                           : {{(DATA_W-BYTE_W){1'b0}}, sum[BYTE_W-1:0]};
        if (is_sub) begin
            n_data.cf = !sum[DATA_W];
            n_data.af = !nib[4];
        end else begin
            n_data.cf = i_req.word_size ? sum[DATA_W] : sum[BYTE_W];
            n_data.af = nib[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/xasc_flags.sv
// stage 2: overflow, parity, zero and sign from the raw result
module xasc_flags (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  xasc_pkg::t_arith i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output xasc_pkg::t_stat  o_data
);
    import xasc_pkg::*;

    logic   r_valid;
    t_stat  r_data;
    t_stat  n_data;
    logic   advance;
    logic   sa;
    logic   sb;
    logic   sr;

    assign advance = !r_valid || i_ready;
    assign o_ready = advance;

    always_comb begin
        sa = i_data.word_size ? i_data.a[DATA_W-1] : i_data.a[BYTE_W-1];
        sb = i_data.word_size ? i_data.b[DATA_W-1] : i_data.b[BYTE_W-1];
        sr = i_data.word_size ? i_data.r[DATA_W-1] : i_data.r[BYTE_W-1];

        n_data.action = i_data.action;
        n_data.a      = i_data.a;
        n_data.r      = i_data.r;
        n_data.flags  = i_data.flags;
        n_data.cf     = i_data.cf;
        n_data.af     = i_data.af;
        n_data.pf     = ~^i_data.r[BYTE_W-1:0];
        n_data.zf     = (i_data.r == '0);
        n_data.sf     = sr;
        if (i_data.action == ACT_ADD) begin
            n_data.of = (sa ^ sr) & (sb ^ sr);
        end else begin
            n_data.of = (sa ^ sb) & (sa ^ sr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/xasc_out.sv
// stage 3: result selection, flags word merge and output register
module xasc_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  xasc_pkg::t_stat i_data,
    xasc_rsp_if.source      o_rsp
);
    import xasc_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_result;
    logic [DATA_W-1:0] r_flags;
    logic [DATA_W-1:0] n_result;
    logic [DATA_W-1:0] n_flags;
    logic [DATA_W-1:0] nf;
    logic              advance;

    assign advance = !r_valid || o_rsp.ready;
    assign o_ready = advance;

    always_comb begin
        nf              = '0;
        nf[FLAG_CF_BIT] = i_data.cf;
        nf[FLAG_PF_BIT] = i_data.pf;
        nf[FLAG_AF_BIT] = i_data.af;
        nf[FLAG_ZF_BIT] = i_data.zf;
        nf[FLAG_SF_BIT] = i_data.sf;
        nf[FLAG_OF_BIT] = i_data.of;
        case (i_data.action)
            ACT_ADD, ACT_SUB: begin
                n_result = i_data.r;
                n_flags  = (i_data.flags & ~ARITH_FLAGS_MASK) | nf;
            end
            ACT_CMP: begin
                n_result = i_data.a;
                n_flags  = (i_data.flags & ~ARITH_FLAGS_MASK) | nf;
            end
            default: begin
                // unused code leaves flags untouched
                n_result = i_data.a;
                n_flags  = i_data.flags;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_result <= n_result;
            r_flags  <= n_flags;
        end
    end

    assign o_rsp.valid      = r_valid;
    assign o_rsp.alu_result = r_result;
    assign o_rsp.flags_out  = r_flags;

endmodule
